// ----- rtl/core/cif_token_splitter_macros.svh -----
// Assertion macros shared by the token splitter RTL
`ifndef CIF_TOKEN_SPLITTER_MACROS_SVH
`define CIF_TOKEN_SPLITTER_MACROS_SVH

`ifndef SYNTHESIS

`define CTS_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("cts assertion failed");

`define CTS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("cts assertion failed");

`else

`define CTS_ASSERT_IMPL(label, clk, rst, ante, cons)

`define CTS_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

// ----- rtl/core/cts_pkg.sv -----
`default_nettype none

package cts_pkg;

   localparam int LINE_BITS = 24;
   localparam logic [LINE_BITS-1:0] LINE_MAX = {LINE_BITS{1'b1}};
   localparam logic [LINE_BITS-1:0] LINE_ONE = {{(LINE_BITS-1){1'b0}}, 1'b1};

   localparam logic [7:0] CH_SPACE  = 8'h20;
   localparam logic [7:0] CH_TAB    = 8'h09;
   localparam logic [7:0] CH_CR     = 8'h0d;
   localparam logic [7:0] CH_LF     = 8'h0a;
   localparam logic [7:0] CH_SQUOTE = 8'h27;
   localparam logic [7:0] CH_DQUOTE = 8'h22;
   localparam logic [7:0] CH_SEMI   = 8'h3b;
   localparam logic [7:0] CH_EOS    = 8'hff;

   typedef enum logic [2:0] {
      CLS_BLANK  = 3'd0,
      CLS_EOL    = 3'd1,
      CLS_SQUOTE = 3'd2,
      CLS_DQUOTE = 3'd3,
      CLS_OTHER  = 3'd4,
      CLS_SEMI   = 3'd5
   } cls_type;

   typedef enum logic [1:0] {
      OPEN_PLAIN  = 2'd0,
      OPEN_SQUOTE = 2'd1,
      OPEN_DQUOTE = 2'd2,
      OPEN_SEMI   = 2'd3
   } opener_type;

   typedef enum logic [1:0] {
      KIND_CHAR  = 2'd0,
      KIND_END   = 2'd1,
      KIND_ERROR = 2'd2
   } kind_type;

   localparam logic signed [3:0] NEXT_ERR = -4'sd2;
   localparam logic signed [3:0] NEXT_END = -4'sd1;
   localparam logic signed [3:0] NEXT_APPEND_MIN = 4'sd2;

   localparam logic signed [3:0] SCAN_TABLE [8][6] = '{
      '{ 4'sd1,  4'sd0,  4'sd2,  4'sd3,  4'sd4,  4'sd5},
      '{ 4'sd1,  4'sd0,  4'sd2,  4'sd3,  4'sd4,  4'sd4},
      '{ 4'sd2, -4'sd2, -4'sd1,  4'sd2,  4'sd2,  4'sd2},
      '{ 4'sd3, -4'sd2,  4'sd3, -4'sd1,  4'sd3,  4'sd3},
      '{-4'sd1, -4'sd1, -4'sd2, -4'sd2,  4'sd4,  4'sd4},
      '{ 4'sd5,  4'sd6,  4'sd5,  4'sd5,  4'sd5,  4'sd5},
      '{ 4'sd5,  4'sd6,  4'sd5,  4'sd5,  4'sd5,  4'sd7},
      '{ 4'sd7, -4'sd1,  4'sd5,  4'sd5,  4'sd5,  4'sd5}
   };

   typedef struct packed {
      kind_type             kind;
      logic [7:0]           char_out;
      logic                 empty_token;
      logic [LINE_BITS-1:0] line_number;
      logic                 last;
   } result_type;

   typedef struct packed {
      result_type [1:0] res;
      logic [1:0]       count;
   } batch_type;

   function automatic cls_type classify(input logic [7:0] b);
      cls_type c;
      if (b == CH_SPACE || b == CH_TAB) c = CLS_BLANK;
      else if (b == CH_CR || b == CH_LF) c = CLS_EOL;
      else if (b == CH_SQUOTE) c = CLS_SQUOTE;
      else if (b == CH_DQUOTE) c = CLS_DQUOTE;
      else if (b == CH_SEMI) c = CLS_SEMI;
      else c = CLS_OTHER;
      return c;
   endfunction

endpackage

`default_nettype wire

// ----- rtl/core/cts_scan.sv -----
`default_nettype none

module cts_scan (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             accept,
   input  wire logic [7:0]       byte_in,
   input  wire logic             stream_end,
   output cts_pkg::batch_type    batch
);

   `include "cif_token_splitter_macros.svh"

   logic [2:0]                    state_ff, state_in;
   logic [7:0]                    held_ff, held_in;
   logic                          held_valid_ff, held_valid_in;
   cts_pkg::opener_type           opener_ff, opener_in;
   logic [1:0]                    len_ff, len_in;
   logic [cts_pkg::LINE_BITS-1:0] line_ff, line_in;
   logic                          err_ff, err_in;

   logic                          is_end;
   logic [cts_pkg::LINE_BITS-1:0] lf_line;
   logic [cts_pkg::LINE_BITS-1:0] fin_line;
   cts_pkg::cls_type              cls;
   logic signed [3:0]             nxt;
   logic                          do_finish;
   logic [1:0]                    n;
   cts_pkg::result_type [1:0]     res;

   function automatic cts_pkg::result_type mk(input cts_pkg::kind_type k,
                                              input logic [7:0] ch,
                                              input logic e,
                                              input logic [cts_pkg::LINE_BITS-1:0] ln);
      cts_pkg::result_type r;
      r.kind        = k;
      r.char_out    = ch;
      r.empty_token = e;
      r.line_number = ln;
      r.last        = 1'b0;
      return r;
   endfunction

   always_comb begin
      is_end    = stream_end || (byte_in == cts_pkg::CH_EOS);
      lf_line   = (byte_in == cts_pkg::CH_LF && line_ff != cts_pkg::LINE_MAX)
                  ? line_ff + cts_pkg::LINE_ONE : line_ff;
      cls       = cts_pkg::classify(byte_in);
      nxt       = cts_pkg::SCAN_TABLE[state_ff][cls];

      state_in      = state_ff;
      held_in       = held_ff;
      held_valid_in = held_valid_ff;
      opener_in     = opener_ff;
      len_in        = len_ff;
      line_in       = line_ff;
      err_in        = err_ff;
      n             = 2'd0;
      res           = '0;
      do_finish     = 1'b0;
      fin_line      = line_ff;

      if (is_end) begin
         do_finish     = !err_ff;
         state_in      = 3'd0;
         held_in       = 8'd0;
         held_valid_in = 1'b0;
         opener_in     = cts_pkg::OPEN_PLAIN;
         len_in        = 2'd0;
         line_in       = cts_pkg::LINE_ONE;
         err_in        = 1'b0;
      end else if (!err_ff) begin
         line_in = lf_line;
         if (nxt == cts_pkg::NEXT_ERR) begin
            res[0] = mk(cts_pkg::KIND_ERROR, 8'd0, 1'b0, lf_line);
            n      = 2'd1;
            err_in = 1'b1;
         end else if (nxt == cts_pkg::NEXT_END) begin
            do_finish     = 1'b1;
            fin_line      = lf_line;
            state_in      = 3'd0;
            held_in       = 8'd0;
            held_valid_in = 1'b0;
            opener_in     = cts_pkg::OPEN_PLAIN;
            len_in        = 2'd0;
         end else if (nxt >= cts_pkg::NEXT_APPEND_MIN) begin
            if (len_ff == 2'd0) begin
               priority if (cls == cts_pkg::CLS_SQUOTE) opener_in = cts_pkg::OPEN_SQUOTE;
               else if (cls == cts_pkg::CLS_DQUOTE) opener_in = cts_pkg::OPEN_DQUOTE;
               else if (cls == cts_pkg::CLS_SEMI) opener_in = cts_pkg::OPEN_SEMI;
               else opener_in = cts_pkg::OPEN_PLAIN;
            end else if (held_valid_ff &&
                         !(len_ff == 2'd1 && opener_ff != cts_pkg::OPEN_PLAIN)) begin
               res[0] = mk(cts_pkg::KIND_CHAR, held_ff, 1'b0, lf_line);
               n      = 2'd1;
            end
            held_in       = byte_in;
            held_valid_in = 1'b1;
            len_in        = (len_ff == 2'd3) ? 2'd3 : len_ff + 2'd1;
            state_in      = nxt[2:0];
         end
      end

      if (do_finish) begin
         if (held_valid_ff && opener_ff != cts_pkg::OPEN_SEMI) begin
            res[0] = mk(cts_pkg::KIND_CHAR, held_ff, 1'b0, fin_line);
            n      = 2'd1;
         end
         res[n[0]] = mk(cts_pkg::KIND_END, 8'd0,
                        (opener_ff == cts_pkg::OPEN_SEMI) ? (len_ff <= 2'd2)
                                                          : (len_ff == 2'd0),
                        fin_line);
         n = n + 2'd1;
      end

      if (n == 2'd1) res[0].last = 1'b1;
      if (n == 2'd2) res[1].last = 1'b1;

      batch.res   = res;
      batch.count = n;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= 3'd0;
         held_ff       <= 8'd0;
         held_valid_ff <= 1'b0;
         opener_ff     <= cts_pkg::OPEN_PLAIN;
         len_ff        <= 2'd0;
         line_ff       <= cts_pkg::LINE_ONE;
         err_ff        <= 1'b0;
      end else if (accept) begin
         state_ff      <= state_in;
         held_ff       <= held_in;
         held_valid_ff <= held_valid_in;
         opener_ff     <= opener_in;
         len_ff        <= len_in;
         line_ff       <= line_in;
         err_ff        <= err_in;
      end
   end

   `CTS_ASSERT_IMPL(a_err_silent, clock, reset, err_ff && !is_end, n == 2'd0)
   `CTS_ASSERT_NEXT(a_err_one_result, clock, reset, accept && !err_ff && err_in, err_ff)

endmodule

`default_nettype wire

// ----- rtl/core/cts_out_queue.sv -----
`default_nettype none

module cts_out_queue (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               push,
   input  wire cts_pkg::batch_type batch,
   output logic                    push_ready,
   output logic                    out_valid,
   input  wire logic               out_ready,
   output cts_pkg::result_type     out_res
);

   `include "cif_token_splitter_macros.svh"

   cts_pkg::result_type e0_ff, e0_in, e1_ff, e1_in;
   logic [1:0]          count_ff, count_in;
   logic                pop;
   logic [1:0]          cnt_after;

   always_comb begin
      pop        = (count_ff != 2'd0) && out_ready;
      cnt_after  = count_ff - {1'b0, pop};
      push_ready = (cnt_after == 2'd0);
      e1_in      = e1_ff;
      e0_in      = (count_ff == 2'd2 && pop) ? e1_ff : e0_ff;
      count_in   = cnt_after;
      if (push) begin
         e0_in    = batch.res[0];
         e1_in    = batch.res[1];
         count_in = batch.count;
      end
      out_valid = (count_ff != 2'd0);
      out_res   = e0_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 2'd0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      e0_ff <= e0_in;
      e1_ff <= e1_in;
   end

   `CTS_ASSERT_IMPL(a_full_stalls, clock, reset, count_ff == 2'd2, !push_ready)
   `CTS_ASSERT_IMPL(a_push_empty, clock, reset, push, cnt_after == 2'd0)
   `CTS_ASSERT_IMPL(a_head_not_last, clock, reset, count_ff == 2'd2, !e0_ff.last)

endmodule

`default_nettype wire

// ----- rtl/core/cif_token_splitter.sv -----
//  channel | dir | tdata                                   | tuser    | tlast
//  req     | in  | [7:0] byte_in                           | -        | stream_end
//  rsp     | out | [7:0] char_out [8] empty_token          | [1:0]    | last
//          |     | [32:9] line_number [39:33] zero         | kind     |
//
//  One input word per cycle while the result side keeps up; the byte is scanned in the
//  cycle it is taken and its results are presented from the queue the next cycle.
//  Words giving two results fill the two-entry result queue; req_tready stays low until
//  the second result is taken.
//  Reset (synchronous) clears scan state, sets the line count to one and
//  empties the queue. No clearing pass.
`default_nettype none

module cif_token_splitter (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,   // [7:0] byte_in
   input  wire logic        req_tlast,   // stream_end
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [39:0]      rsp_tdata,   // [7:0] char_out, [8] empty_token, [32:9] line_number
   output logic [1:0]       rsp_tuser,   // [1:0] kind
   output logic             rsp_tlast    // last
);

   logic                accept;
   logic                push_ready;
   cts_pkg::batch_type  batch;
   cts_pkg::result_type head;

   assign req_tready = push_ready;
   assign accept     = req_tvalid && push_ready;

   cts_scan u_scan (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .byte_in    (req_tdata),
      .stream_end (req_tlast),
      .batch      (batch)
   );

   cts_out_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (accept),
      .batch      (batch),
      .push_ready (push_ready),
      .out_valid  (rsp_tvalid),
      .out_ready  (rsp_tready),
      .out_res    (head)
   );

   assign rsp_tdata = {7'd0, head.line_number, head.empty_token, head.char_out};
   assign rsp_tuser = head.kind;
   assign rsp_tlast = head.last;

endmodule

`default_nettype wire
